// ===== rtl/rwcc_pkg.sv =====
// Constants, codes and helper functions shared by the Reno window congestion control unit.
package rwcc_pkg;

  localparam int unsigned WINDOW_SLOTS = 32;
  localparam int unsigned SLOT_W       = $clog2(WINDOW_SLOTS);
  localparam int unsigned WIN_W        = $clog2(WINDOW_SLOTS + 1);
  localparam int unsigned OFF_W        = WIN_W + 1;

  localparam int unsigned SEQ_W  = 32;
  localparam int unsigned CWND_W = 10;
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned ACT_W  = 2;
  localparam int unsigned PH_W   = 2;
  localparam int unsigned SIDX_W = 5;
  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W  = 32;

  // tdata widths, rounded up to whole bytes
  localparam int unsigned IN_FIELDS_W  = CMD_W + SEQ_W + SIDX_W;
  localparam int unsigned IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_FIELDS_W = ACT_W + 2 * SEQ_W + 2 * CWND_W + PH_W + 1;
  localparam int unsigned OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [CWND_W-1:0] CWND_MAX      = 10'd1023;
  localparam logic [CWND_W-1:0] CWND_RESET    = 10'd1;
  localparam logic [CWND_W-1:0] THRESH_RESET  = 10'd16;
  localparam logic [CWND_W-1:0] RECOVER_BUMP  = 10'd3;
  localparam logic [1:0]        DUP_LIMIT     = 2'd3;

  localparam logic [CMD_W-1:0] CMD_SEND    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ACK     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TIMEOUT = 2'd2;

  localparam logic [ACT_W-1:0] ACT_NONE = 2'd0;
  localparam logic [ACT_W-1:0] ACT_NEW  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_RETX = 2'd2;

  localparam logic [PH_W-1:0] PH_SLOW    = 2'd0;
  localparam logic [PH_W-1:0] PH_AVOID   = 2'd1;
  localparam logic [PH_W-1:0] PH_RECOVER = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_TOTAL_PACKETS = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_INIT_THRESH   = 1'd1;

  typedef logic [1:0] slot_t;
  localparam slot_t SLOT_EMPTY = 2'd0;
  localparam slot_t SLOT_SENT  = 2'd1;
  localparam slot_t SLOT_ACKED = 2'd2;

  function automatic logic [CWND_W-1:0] cwnd_inc(input logic [CWND_W-1:0] c);
    return (c == CWND_MAX) ? CWND_MAX : c + 1'b1;
  endfunction

  function automatic logic [CWND_W-1:0] half_min_one(input logic [CWND_W-1:0] c);
    logic [CWND_W-1:0] h;
    h = c >> 1;
    return (h == '0) ? CWND_W'(1) : h;
  endfunction

endpackage

// ===== rtl/reno_window_congestion_control_unit.sv =====
// Reno window congestion control unit: send window, slot map and congestion state in one pass.
// A request passes the input register and then the result register before it reaches m_axis.
// Throughput: one request per cycle without back-pressure; slot map find and shift are combinational.
// The next request sees the window state left by the previous one in the following cycle.
// Reset (rst, synchronous): slot map empty, base and next sequence 0, cwnd 1, threshold 16,
// slow start, counters cleared, total_packets 0; no pipeline stage holds a request.
module reno_window_congestion_control_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rwcc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [rwcc_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // cmd[1:0], ack_number[33:2], slot_index[38:34], zero pad
  input  logic [rwcc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // action[1:0], packet_seq[33:2], window_base[65:34], cong_window[75:66],
  // slow_threshold[85:76], phase_out[87:86], transfer_done[88], zero pad
  output logic [rwcc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
  import rwcc_pkg::*;

  // input register
  logic              in_valid;
  logic [CMD_W-1:0]  in_cmd;
  logic [SEQ_W-1:0]  in_ack;
  logic [SIDX_W-1:0] in_slot;
  logic              advance;

  // window and congestion state
  logic [SEQ_W-1:0]  total_packets;
  slot_t             slot_map [WINDOW_SLOTS];
  logic [SEQ_W-1:0]  base_seq;
  logic [SEQ_W-1:0]  next_seq;
  logic [CWND_W-1:0] cwnd_reg;
  logic [CWND_W-1:0] threshold_reg;
  logic [PH_W-1:0]   phase_reg;
  logic [1:0]        off_base_count;
  logic [CWND_W-1:0] avoid_count;

  slot_t             slot_map_next [WINDOW_SLOTS];
  logic [SEQ_W-1:0]  base_seq_next;
  logic [SEQ_W-1:0]  next_seq_next;
  logic [CWND_W-1:0] cwnd_next;
  logic [CWND_W-1:0] threshold_next;
  logic [PH_W-1:0]   phase_next;
  logic [1:0]        off_base_next;
  logic [CWND_W-1:0] avoid_next;
  logic [ACT_W-1:0]  action_next;
  logic [SEQ_W-1:0]  pseq_next;

  // result register
  logic              out_valid;
  logic [ACT_W-1:0]  out_action;
  logic [SEQ_W-1:0]  out_pseq;
  logic [SEQ_W-1:0]  out_base;
  logic [CWND_W-1:0] out_cwnd;
  logic [CWND_W-1:0] out_thresh;
  logic [PH_W-1:0]   out_phase;
  logic              out_done;

  assign cfg_ready     = 1'b1;
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}}, out_done, out_phase,
                          out_thresh, out_cwnd, out_base, out_pseq, out_action};

  always_comb begin
    logic [WIN_W-1:0]  win;
    logic [SEQ_W-1:0]  seq_off;
    logic              ge;
    logic              at_base;
    logic              in_win;
    logic              dup_check;
    logic [OFF_W-1:0]  off;
    logic [OFF_W:0]    src;
    slot_t             marked [WINDOW_SLOTS];

    for (int i = 0; i < WINDOW_SLOTS; i++) begin
      slot_map_next[i] = slot_map[i];
      marked[i]        = slot_map[i];
    end
    base_seq_next  = base_seq;
    next_seq_next  = next_seq;
    cwnd_next      = cwnd_reg;
    threshold_next = threshold_reg;
    phase_next     = phase_reg;
    off_base_next  = off_base_count;
    avoid_next     = avoid_count;
    action_next    = ACT_NONE;
    pseq_next      = '0;
    dup_check      = 1'b0;
    off            = '0;
    src            = '0;

    win     = (cwnd_reg < CWND_W'(WINDOW_SLOTS)) ? WIN_W'(cwnd_reg) : WIN_W'(WINDOW_SLOTS);
    ge      = in_ack >= base_seq;
    at_base = in_ack == base_seq;
    seq_off = (in_cmd == CMD_SEND) ? next_seq - base_seq : in_ack - base_seq;
    in_win  = seq_off < SEQ_W'(win);

    case (in_cmd)
      CMD_SEND: begin
        if (in_win && next_seq < total_packets) begin
          slot_map_next[seq_off[SLOT_W-1:0]] = SLOT_SENT;
          action_next   = ACT_NEW;
          pseq_next     = next_seq;
          next_seq_next = next_seq + 1'b1;
        end
      end
      CMD_ACK: begin
        if (ge && in_win) begin
          case (phase_reg)
            PH_SLOW: begin
              if (cwnd_reg <= threshold_reg) cwnd_next = cwnd_inc(cwnd_reg);
              else                           phase_next = PH_AVOID;
              dup_check = 1'b1;
            end
            PH_AVOID: begin
              avoid_next = avoid_count + 1'b1;
              if (avoid_next == cwnd_reg) begin
                cwnd_next  = cwnd_inc(cwnd_reg);
                avoid_next = '0;
              end
              dup_check = 1'b1;
            end
            PH_RECOVER: begin
              if (at_base) begin
                cwnd_next     = threshold_reg;
                off_base_next = '0;
                phase_next    = PH_AVOID;
              end else begin
                cwnd_next = cwnd_inc(cwnd_reg);
              end
            end
            default: ;
          endcase
          if (dup_check) begin
            off_base_next = at_base ? 2'd0 : off_base_count + 1'b1;
            if (off_base_next == DUP_LIMIT) begin
              action_next    = ACT_RETX;
              pseq_next      = base_seq;
              threshold_next = half_min_one(cwnd_next);
              cwnd_next      = threshold_next + RECOVER_BUMP;
              phase_next     = PH_RECOVER;
              off_base_next  = '0;
            end
          end
        end
        if (ge && seq_off < SEQ_W'(WINDOW_SLOTS) &&
            slot_map[seq_off[SLOT_W-1:0]] != SLOT_EMPTY) begin
          marked[seq_off[SLOT_W-1:0]]        = SLOT_ACKED;
          slot_map_next[seq_off[SLOT_W-1:0]] = SLOT_ACKED;
          if (at_base) begin
            // count leading acked slots, then shift the map down past them
            off = OFF_W'(WINDOW_SLOTS);
            for (int i = WINDOW_SLOTS - 1; i >= 0; i--) begin
              if (marked[i] != SLOT_ACKED) off = OFF_W'(i);
            end
            for (int i = 0; i < WINDOW_SLOTS; i++) begin
              src = (OFF_W + 1)'(i) + {1'b0, off};
              slot_map_next[i] = (src < (OFF_W + 1)'(WINDOW_SLOTS)) ?
                                 marked[src[SLOT_W-1:0]] : SLOT_EMPTY;
            end
            base_seq_next = base_seq + SEQ_W'(off);
          end
        end
      end
      CMD_TIMEOUT: begin
        if (slot_map[in_slot[SLOT_W-1:0]] == SLOT_SENT) begin
          action_next    = ACT_RETX;
          pseq_next      = base_seq + SEQ_W'(in_slot);
          threshold_next = half_min_one(cwnd_reg);
          cwnd_next      = CWND_RESET;
          phase_next     = PH_SLOW;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_cmd  <= s_axis_tdata[CMD_W-1:0];
      in_ack  <= s_axis_tdata[CMD_W+SEQ_W-1:CMD_W];
      in_slot <= s_axis_tdata[IN_FIELDS_W-1:CMD_W+SEQ_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total_packets  <= '0;
      base_seq       <= '0;
      next_seq       <= '0;
      cwnd_reg       <= CWND_RESET;
      threshold_reg  <= THRESH_RESET;
      phase_reg      <= PH_SLOW;
      off_base_count <= '0;
      avoid_count    <= '0;
      for (int i = 0; i < WINDOW_SLOTS; i++) slot_map[i] <= SLOT_EMPTY;
    end else begin
      if (advance) begin
        base_seq       <= base_seq_next;
        next_seq       <= next_seq_next;
        cwnd_reg       <= cwnd_next;
        threshold_reg  <= threshold_next;
        phase_reg      <= phase_next;
        off_base_count <= off_base_next;
        avoid_count    <= avoid_next;
        for (int i = 0; i < WINDOW_SLOTS; i++) slot_map[i] <= slot_map_next[i];
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TOTAL_PACKETS: total_packets <= cfg_data[SEQ_W-1:0];
          REG_INIT_THRESH: begin
            threshold_reg <= (cfg_data[CWND_W-1:0] == '0) ? CWND_W'(1) : cfg_data[CWND_W-1:0];
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_action <= action_next;
      out_pseq   <= pseq_next;
      out_base   <= base_seq_next;
      out_cwnd   <= cwnd_next;
      out_thresh <= threshold_next;
      out_phase  <= phase_next;
      out_done   <= base_seq_next >= total_packets;
    end
  end

  // outstanding sequence span never exceeds the slot map
  assert property (@(posedge clk) disable iff (rst)
    (next_seq - base_seq) <= SEQ_W'(WINDOW_SLOTS))
    else $error("send span exceeds slot map");

  assert property (@(posedge clk) disable iff (rst)
    cwnd_reg != '0 && threshold_reg != '0)
    else $error("cwnd or threshold reached zero");

  // a retransmission leaves slow start or fast recovery, never avoidance
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_action == ACT_RETX |-> out_phase != PH_AVOID)
    else $error("retransmit reported in avoidance");

  // a new packet always advances the next sequence number
  assert property (@(posedge clk) disable iff (rst)
    advance && action_next == ACT_NEW |=> next_seq == $past(next_seq) + 1'b1)
    else $error("new packet without sequence advance");

endmodule
